// ----- rtl/mplc_pkg.sv -----
// Shared types, codes and constants for the motor position limit controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package mplc_pkg;

	// Width of the counted position and of the target field.
	localparam int unsigned PosBits = 16;
	// Largest PWM compare value; the timer period is 100 counts.
	localparam int unsigned DutyMax = 100 - 1;
	// Register reset values.
	localparam int unsigned DutyReset = 50;
	localparam int unsigned WindowReset = 50;

	typedef logic signed [PosBits-1:0] pos_t;
	typedef logic [6:0] duty_t;
	typedef logic [7:0] count_t;

	// Input item commands.
	typedef enum logic [1:0] {
		CMD_SET_TARGET = 2'd0,
		CMD_PULSE      = 2'd1,
		CMD_HOME       = 2'd2,
		CMD_HOME_TICK  = 2'd3
	} cmd_t;

	// Motor direction codes as shown on the result channel.
	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_IN   = 2'd1,
		DIR_OUT  = 2'd2
	} dir_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_DRIVE_DUTY   = 1'b0,
		REG_READY_WINDOW = 1'b1
	} reg_idx_t;

	// One input item as held in the input register.
	typedef struct packed {
		cmd_t cmd;
		pos_t target;
		logic low_sw;
		logic high_sw;
	} item_t;

	// Configuration write bundle.
	typedef struct packed {
		logic     we;
		reg_idx_t index;
		logic [7:0] data;
	} cfg_wr_t;

	localparam pos_t PosMax = {1'b0, {(PosBits-1){1'b1}}};
	localparam pos_t PosMin = {1'b1, {(PosBits-1){1'b0}}};

endpackage
`default_nettype wire

// ----- rtl/mplc_in_stage.sv -----
// Input register of the motor position limit controller.
// Depends on mplc_pkg for the item type.
`default_nettype none
module mplc_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mplc_pkg::item_t in_item,
	input  wire logic           advance,
	output logic                valid_s1,
	output mplc_pkg::item_t     item_s1
);
	import mplc_pkg::*;

	// The register takes a new item when empty or when its item moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the held item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mplc_ctrl.sv -----
// Controller state, event update logic and result register.
// Depends on mplc_pkg for types, codes and constants.
`default_nettype none
module mplc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mplc_pkg::cfg_wr_t cfg,
	input  wire logic             valid_s1,
	input  wire mplc_pkg::item_t  item_s1,
	output logic                  advance,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mplc_pkg::dir_t        dir_q,
	output mplc_pkg::duty_t       duty_q,
	output logic                  bridge_q,
	output mplc_pkg::pos_t        pos_q,
	output logic                  max_q,
	output logic                  homing_q
);
	import mplc_pkg::*;

	duty_t  drive_duty_q;
	count_t ready_window_q;
	pos_t   target_q;
	count_t window_q;
	count_t hit_q;

	dir_t   dir_d;
	duty_t  duty_d;
	logic   bridge_d;
	pos_t   pos_d;
	logic   max_d;
	logic   homing_d;
	pos_t   target_d;
	count_t window_d;
	count_t hit_d;

	duty_t  run_duty;
	count_t win_size;
	pos_t   stepped;
	count_t window_inc;
	count_t hit_inc;

	// The state registers double as the result register: they only change
	// when the shown result has been taken or none is shown.
	assign advance = valid_s1 && (!out_valid || out_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_duty_q   <= duty_t'(DutyReset);
			ready_window_q <= count_t'(WindowReset);
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_DRIVE_DUTY:   drive_duty_q <= cfg.data[6:0];
				REG_READY_WINDOW: ready_window_q <= cfg.data;
				default:          ;
			endcase
		end
	end

	// Duty saturates at the period limit; a zero window acts as one sample.
	assign run_duty = (drive_duty_q > duty_t'(DutyMax)) ? duty_t'(DutyMax) : drive_duty_q;
	assign win_size = (ready_window_q == '0) ? count_t'(1) : ready_window_q;
	assign window_inc = window_q + count_t'(1);
	assign hit_inc = hit_q + count_t'(item_s1.low_sw);

	// One saturating step of the position in the current direction.
	always_comb begin
		stepped = pos_q;
		if (dir_q == DIR_IN && pos_q != PosMax) begin
			stepped = pos_q + pos_t'(1);
		end else if (dir_q == DIR_OUT && pos_q != PosMin) begin
			stepped = pos_q - pos_t'(1);
		end
	end

	// Next state for the held item.
	always_comb begin
		dir_d    = dir_q;
		duty_d   = duty_q;
		bridge_d = bridge_q;
		pos_d    = pos_q;
		max_d    = max_q;
		homing_d = homing_q;
		target_d = target_q;
		window_d = window_q;
		hit_d    = hit_q;
		unique case (item_s1.cmd)
			CMD_SET_TARGET: begin
				target_d = item_s1.target;
				if (item_s1.target < pos_q) begin
					duty_d = run_duty;
					dir_d  = DIR_OUT;
				end else if (item_s1.target > pos_q && !max_q) begin
					duty_d = run_duty;
					dir_d  = DIR_IN;
				end
			end
			CMD_PULSE: begin
				pos_d = item_s1.low_sw ? pos_t'(0) : stepped;
				if (pos_d == target_q) begin
					dir_d = DIR_STOP;
				end
				if (item_s1.high_sw && dir_d == DIR_IN) begin
					max_d = 1'b1;
					dir_d = DIR_STOP;
				end else begin
					max_d = 1'b0;
				end
			end
			CMD_HOME: begin
				bridge_d = 1'b1;
				dir_d    = DIR_OUT;
				duty_d   = run_duty;
				homing_d = 1'b1;
				window_d = '0;
				hit_d    = '0;
			end
			CMD_HOME_TICK: begin
				if (homing_q) begin
					window_d = window_inc;
					hit_d    = hit_inc;
					if (window_inc >= win_size) begin
						// A full window of active samples ends homing.
						if (hit_inc == window_inc) begin
							duty_d   = '0;
							dir_d    = DIR_STOP;
							bridge_d = 1'b0;
							homing_d = 1'b0;
						end
						window_d = '0;
						hit_d    = '0;
					end
				end
			end
			default: ;
		endcase
	end

	// State and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			dir_q     <= DIR_STOP;
			duty_q    <= '0;
			bridge_q  <= 1'b0;
			pos_q     <= '0;
			max_q     <= 1'b0;
			homing_q  <= 1'b0;
			target_q  <= '0;
			window_q  <= '0;
			hit_q     <= '0;
		end else begin
			if (advance) begin
				out_valid <= 1'b1;
				dir_q     <= dir_d;
				duty_q    <= duty_d;
				bridge_q  <= bridge_d;
				pos_q     <= pos_d;
				max_q     <= max_d;
				homing_q  <= homing_d;
				target_q  <= target_d;
				window_q  <= window_d;
				hit_q     <= hit_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/motor_position_limit_controller_core.sv -----
// Top level of the motor position limit controller.
// Depends on mplc_pkg, mplc_in_stage and mplc_ctrl.
//
// Usage: events enter on the input channel (in_valid/in_ready) with cmd,
// target and the two limit switch levels. Every item yields exactly one
// result on the output channel (out_valid/out_ready) showing the motor
// direction, PWM duty, bridge enable, position, at-max flag and homing
// status as they stand after that event.
// From input acceptance to out_valid, the item waits in the input register
// while the update logic forms the next controller state, which is
// registered and itself serves as the result register.
// Throughput is one item per cycle while the receiver takes every result;
// the single state update per cycle is what sets that figure.
// When the receiver stalls, the result holds and the input register still
// takes one more item; after that in_ready drops until the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant to happen only while the block is idle.
// Reset clears all state, empties both registers and loads both
// configuration registers with 50.
`default_nettype none
module motor_position_limit_controller_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          cmd,
	input  wire logic signed [15:0]  target,
	input  wire logic                low_switch_active,
	input  wire logic                high_switch_active,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               direction,
	output logic [6:0]               pwm_duty,
	output logic                     driver_enable,
	output logic signed [15:0]       position,
	output logic                     at_max,
	output logic                     homing_busy
);
	import mplc_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	cfg_wr_t cfg;
	dir_t    dir_q;

	assign in_item = '{cmd: cmd_t'(cmd), target: pos_t'(target),
		low_sw: low_switch_active, high_sw: high_switch_active};
	assign cfg = '{we: cfg_we, index: reg_idx_t'(cfg_index), data: cfg_data};

	// Input register.
	mplc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// State update and result.
	mplc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dir_q     (dir_q),
		.duty_q    (pwm_duty),
		.bridge_q  (driver_enable),
		.pos_q     (position),
		.max_q     (at_max),
		.homing_q  (homing_busy)
	);

	assign direction = 2'(dir_q);

endmodule
`default_nettype wire

// ----- rtl/mplc_checker.sv -----
// Port-level checks for the motor position limit controller.
// Depends on mplc_pkg; bound to motor_position_limit_controller_core.
`default_nettype none
module mplc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  direction,
	input wire logic        driver_enable,
	input wire logic        homing_busy,
	input wire logic [15:0] position
);
	import mplc_pkg::*;

	// The bridge is always enabled while homing runs.
	a_homing_bridge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && homing_busy |-> driver_enable)
		else $error("homing without bridge enable");

	// Direction never shows the unused code.
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (direction == 2'(DIR_STOP) || direction == 2'(DIR_IN)
			|| direction == 2'(DIR_OUT)))
		else $error("invalid direction code");

	// A stalled result keeps its position.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position))
		else $error("stalled result changed");

	// A stalled input item, with the result also stalled, keeps valid high.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item dropped while stalled");

endmodule

bind motor_position_limit_controller_core mplc_checker u_mplc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.direction     (direction),
	.driver_enable (driver_enable),
	.homing_busy   (homing_busy),
	.position      (position)
);
`default_nettype wire

// ----- dv/motor_position_limit_controller_core_tb.sv -----
// Self-checking testbench for motor_position_limit_controller_core: a directed table,
// an outward walk during homing, and random phases per register setting.
// Depends on mplc_pkg and the controller RTL; results are checked against an in-bench predictor.
`default_nettype none
module motor_position_limit_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mplc_pkg::*;

	// One result item as seen on the output channel.
	typedef struct packed {
		dir_t  dir;
		duty_t duty;
		logic  enable;
		pos_t  pos;
		logic  at_max;
		logic  busy;
	} motion_t;

	typedef enum logic {
		ROW_EVENT,
		ROW_WRITE
	} row_kind_t;

	// One row of the directed stimulus table.
	typedef struct {
		row_kind_t  kind;
		cmd_t       op;
		pos_t       tgt;
		logic       lo;
		logic       hi;
		bit         typed;
		motion_t    want;
		reg_idx_t   idx;
		logic [7:0] data;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [7:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd = '0;
	logic signed [15:0] target = '0;
	logic              low_switch_active = 1'b0;
	logic              high_switch_active = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        direction;
	logic [6:0]        pwm_duty;
	logic              driver_enable;
	logic signed [15:0] position;
	logic              at_max;
	logic              homing_busy;

	motor_position_limit_controller_core dut (.*);

	always #1 clk = ~clk;

	// Predictor copy of the register settings and the controller state.
	logic [6:0] cfg_duty = 7'd50;
	logic [7:0] cfg_window = 8'd50;
	pos_t       tgt_pos = '0;
	pos_t       cur_pos = '0;
	dir_t       motor_dir = DIR_STOP;
	logic       at_limit = 1'b0;
	duty_t      duty_now = '0;
	logic       bridge = 1'b0;
	logic       homing = 1'b0;
	count_t     win_cnt = '0;
	count_t     hit_cnt = '0;

	motion_t   motion_due[$];
	plan_row_t script[$];
	int        failures = 0;
	int        taken = 0;
	bit        send_burst = 1'b0;
	bit        take_burst = 1'b0;

	// Compare value used while moving; settings above the period top out at its maximum.
	function automatic duty_t run_duty();
		return (cfg_duty > DutyMax) ? duty_t'(DutyMax) : cfg_duty;
	endfunction

	// Applies one accepted item to the predicted state and returns the result it shows.
	function automatic motion_t next_motion(cmd_t op, pos_t tgt, logic lo, logic hi);
		int     diff;
		int     step_pos;
		count_t win;
		motion_t r;
		case (op)
			CMD_SET_TARGET: begin
				tgt_pos = tgt;
				diff = int'(tgt_pos) - int'(cur_pos);
				if (diff < 0) begin
					duty_now = run_duty();
					motor_dir = DIR_OUT;
				end else if (diff > 0 && !at_limit) begin
					duty_now = run_duty();
					motor_dir = DIR_IN;
				end
			end
			CMD_PULSE: begin
				step_pos = int'(cur_pos);
				if (motor_dir == DIR_IN) step_pos++;
				else if (motor_dir == DIR_OUT) step_pos--;
				if (step_pos > int'(PosMax)) step_pos = int'(PosMax);
				if (step_pos < int'(PosMin)) step_pos = int'(PosMin);
				if (lo) step_pos = 0;
				cur_pos = pos_t'(step_pos);
				if (cur_pos == tgt_pos) motor_dir = DIR_STOP;
				if (hi && motor_dir == DIR_IN) begin
					at_limit = 1'b1;
					motor_dir = DIR_STOP;
				end else begin
					at_limit = 1'b0;
				end
			end
			CMD_HOME: begin
				bridge = 1'b1;
				motor_dir = DIR_OUT;
				duty_now = run_duty();
				homing = 1'b1;
				win_cnt = '0;
				hit_cnt = '0;
			end
			default: begin
				// A window of zero behaves as a window of one sample.
				if (homing) begin
					win = (cfg_window == 0) ? count_t'(1) : cfg_window;
					if (lo) hit_cnt++;
					win_cnt++;
					if (win_cnt >= win) begin
						if (hit_cnt == win_cnt) begin
							duty_now = '0;
							motor_dir = DIR_STOP;
							bridge = 1'b0;
							homing = 1'b0;
						end
						win_cnt = '0;
						hit_cnt = '0;
					end
				end
			end
		endcase
		r = '{motor_dir, duty_now, bridge, cur_pos, at_limit, homing};
		return r;
	endfunction

	function automatic void plan(cmd_t op, int tgt, int lo, int hi);
		plan_row_t row;
		row = '{ROW_EVENT, op, pos_t'(tgt), 1'(lo), 1'(hi), 1'b0, '0, REG_DRIVE_DUTY, '0};
		script.push_back(row);
	endfunction

	function automatic void plan_exp(cmd_t op, int tgt, int lo, int hi, dir_t d,
			int du, int en, int p, int mx, int busy);
		plan_row_t row;
		row = '{ROW_EVENT, op, pos_t'(tgt), 1'(lo), 1'(hi), 1'b1,
			'{d, duty_t'(du), 1'(en), pos_t'(p), 1'(mx), 1'(busy)}, REG_DRIVE_DUTY, '0};
		script.push_back(row);
	endfunction

	function automatic void plan_write(reg_idx_t idx, logic [7:0] data);
		plan_row_t row;
		row = '{ROW_WRITE, CMD_SET_TARGET, '0, 1'b0, 1'b0, 1'b0, '0, idx, data};
		script.push_back(row);
	endfunction

	// Prints one line per failure (up to a cap) and counts every one.
	task automatic note_failure(string msg);
		if (failures < 100) $display("%0t ns: %s", $time, msg);
		failures++;
	endtask

	// Matches one accepted result against the oldest predicted one.
	task automatic check_motion(motion_t got);
		motion_t want;
		if (motion_due.size() == 0) begin
			note_failure("result item with no item outstanding");
			return;
		end
		want = motion_due.pop_front();
		if (got.dir !== want.dir)
			note_failure($sformatf("direction: got %0d, expected %0d", got.dir, want.dir));
		if (got.duty !== want.duty)
			note_failure($sformatf("pwm_duty: got %0d, expected %0d", got.duty, want.duty));
		if (got.enable !== want.enable)
			note_failure($sformatf("driver_enable: got %b, expected %b",
				got.enable, want.enable));
		if (got.pos !== want.pos)
			note_failure($sformatf("position: got %0d, expected %0d",
				$signed(got.pos), $signed(want.pos)));
		if (got.at_max !== want.at_max)
			note_failure($sformatf("at_max: got %b, expected %b", got.at_max, want.at_max));
		if (got.busy !== want.busy)
			note_failure($sformatf("homing_busy: got %b, expected %b", got.busy, want.busy));
	endtask

	// Offers one item after a random gap and records its prediction once accepted.
	// Called right after a rising edge; returns at the edge that accepted the item.
	task automatic drive_event(cmd_t op, pos_t tgt, logic lo, logic hi, bit typed,
			motion_t want);
		int gap;
		motion_t model;
		if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		target <= tgt;
		low_switch_active <= lo;
		high_switch_active <= hi;
		do @(posedge clk); while (!in_ready);
		model = next_motion(op, tgt, lo, hi);
		motion_due.push_back(typed ? want : model);
	endtask

	// Stops offering items and waits until every result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		while (motion_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DRIVE_DUTY) cfg_duty = value[6:0];
		else cfg_window = value;
		@(posedge clk);
	endtask

	// Result side: random stalls, bursts with no stall, and now and then a long hold-off
	// so that the input register fills and in_ready drops.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
			if (taken % 250 == 100) stall = 48;
			else stall = take_burst ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_motion('{dir_t'(direction), pwm_duty, driver_enable, position, at_max,
				homing_busy});
			taken++;
		end
	end

	// Watchdog on the whole run.
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Stimulus: directed table, an outward walk during homing, random phases.
	initial begin
		static logic [7:0] duty_set[6] = '{8'd50, 8'd0, 8'd99, 8'hFF, 8'd0, 8'd75};
		static logic [7:0] window_set[6] = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd0, 8'd4};
		int   counted;
		int   r;
		int   sel;
		int   near;
		int   n;
		cmd_t op;
		pos_t tgt;
		logic lo;
		logic hi;

		// Reset state, a stopped motor, the limit flag and target blocking.
		plan_exp(CMD_HOME_TICK, 0, 1, 0, DIR_STOP, 0, 0, 0, 0, 0);
		plan_exp(CMD_SET_TARGET, 0, 0, 0, DIR_STOP, 0, 0, 0, 0, 0);
		plan_exp(CMD_PULSE, 0, 0, 0, DIR_STOP, 0, 0, 0, 0, 0);
		plan_exp(CMD_SET_TARGET, 32767, 0, 0, DIR_IN, 50, 0, 0, 0, 0);
		plan_exp(CMD_PULSE, 0, 0, 0, DIR_IN, 50, 0, 1, 0, 0);
		plan_exp(CMD_PULSE, 0, 0, 1, DIR_STOP, 50, 0, 2, 1, 0);
		plan_exp(CMD_SET_TARGET, 1000, 0, 0, DIR_STOP, 50, 0, 2, 1, 0);
		plan_exp(CMD_PULSE, 0, 0, 0, DIR_STOP, 50, 0, 2, 0, 0);
		plan_exp(CMD_SET_TARGET, -32768, 0, 0, DIR_OUT, 50, 0, 2, 0, 0);
		plan_exp(CMD_PULSE, 0, 0, 0, DIR_OUT, 50, 0, 1, 0, 0);
		plan_exp(CMD_PULSE, 0, 1, 0, DIR_OUT, 50, 0, 0, 0, 0);
		plan_exp(CMD_PULSE, 0, 1, 1, DIR_OUT, 50, 0, 0, 0, 0);
		// Homing with other events mixed in, then a restart of the window.
		plan_exp(CMD_HOME, 0, 0, 0, DIR_OUT, 50, 1, 0, 0, 1);
		plan(CMD_SET_TARGET, 5, 0, 0);
		plan(CMD_PULSE, 0, 0, 0);
		plan(CMD_HOME, 0, 0, 0);
		plan_write(REG_READY_WINDOW, 8'd2);
		plan(CMD_HOME_TICK, 0, 1, 0);
		plan(CMD_HOME_TICK, 0, 0, 0);
		plan(CMD_HOME_TICK, 0, 1, 0);
		plan_exp(CMD_HOME_TICK, 0, 1, 0, DIR_STOP, 0, 0, 1, 0, 0);
		// A window of zero finishes on the first active sample.
		plan_write(REG_READY_WINDOW, 8'd0);
		plan_write(REG_DRIVE_DUTY, 8'd99);
		plan_exp(CMD_HOME, 0, 0, 0, DIR_OUT, 99, 1, 1, 0, 1);
		plan_exp(CMD_HOME_TICK, 0, 1, 0, DIR_STOP, 0, 0, 1, 0, 0);
		// A duty setting above the period is clipped when used.
		plan_write(REG_DRIVE_DUTY, 8'hE4);
		plan_exp(CMD_SET_TARGET, -5, 0, 0, DIR_OUT, 99, 0, 1, 0, 0);
		plan(CMD_PULSE, 0, 0, 0);
		plan(CMD_PULSE, 0, 0, 0);
		plan_write(REG_DRIVE_DUTY, 8'd0);
		plan_exp(CMD_SET_TARGET, 32767, 0, 0, DIR_IN, 0, 0, -1, 0, 0);
		plan(CMD_PULSE, 0, 0, 1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				settle();
				write_register(script[i].idx, script[i].data);
			end else begin
				drive_event(script[i].op, script[i].tgt, script[i].lo, script[i].hi,
					script[i].typed, script[i].want);
			end
		end

		// Homing with a target above zero drives the count down on every pulse.
		drive_event(CMD_PULSE, '0, 1'b1, 1'b0, 1'b0, '0);
		drive_event(CMD_SET_TARGET, pos_t'(100), 1'b0, 1'b0, 1'b0, '0);
		drive_event(CMD_HOME, '0, 1'b0, 1'b0, 1'b0, '0);
		for (n = 0; n < 100; n++) drive_event(CMD_PULSE, pos_t'($urandom), 1'b0, 1'b0,
			1'b0, '0);
		drive_event(CMD_PULSE, '0, 1'b1, 1'b0, 1'b0, '0);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			write_register(REG_DRIVE_DUTY, (ph == 4) ? 8'($urandom_range(0, 255)) :
				duty_set[ph]);
			write_register(REG_READY_WINDOW, (ph == 4) ? 8'($urandom_range(1, 6)) :
				window_set[ph]);
			counted = 0;
			while (counted < 120) begin
				r = $urandom_range(0, 99);
				tgt = pos_t'($urandom);
				lo = 1'b0;
				hi = 1'b0;
				if (r < 8) begin
					op = cmd_t'($urandom_range(0, 3));
					lo = 1'($urandom_range(0, 1));
					hi = 1'($urandom_range(0, 1));
				end else if (r < 30) begin
					op = CMD_SET_TARGET;
					sel = $urandom_range(0, 9);
					if (sel < 6) begin
						near = int'(cur_pos) + int'($urandom_range(0, 60)) - 30;
						if (near > int'(PosMax)) near = int'(PosMax);
						if (near < int'(PosMin)) near = int'(PosMin);
						tgt = pos_t'(near);
					end else if (sel == 8) begin
						tgt = PosMax;
					end else if (sel == 9) begin
						tgt = PosMin;
					end
				end else if (r < 65) begin
					op = CMD_PULSE;
					lo = ($urandom_range(0, 19) == 0);
					hi = ($urandom_range(0, 9) == 0);
				end else if (r < 70) begin
					op = CMD_HOME;
				end else begin
					// While homing, mostly active samples so that windows complete.
					op = CMD_HOME_TICK;
					lo = homing ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
					hi = 1'($urandom_range(0, 1));
				end
				if (op != CMD_HOME_TICK || homing) counted++;
				drive_event(op, tgt, lo, hi, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		for (n = 0; n < 2000 && motion_due.size() != 0; n++) @(posedge clk);
		repeat (4) @(posedge clk);
		if (motion_due.size() != 0)
			note_failure($sformatf("%0d result items never arrived", motion_due.size()));
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
